/* rtl/core/kptp_pkg.sv */
// Shared types and constants of the knee phase torque profile core.
package kptp_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = TBL_AW + 1;
	localparam int FRAC_W      = 21;
	localparam int PHASE_MAX   = 51472;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	localparam logic [15:0] RST_ONSET     = 16'd1544;
	localparam logic [15:0] RST_OFFSET    = 16'd15441;
	localparam logic [15:0] RST_DAMPING   = 16'd41177;
	localparam logic [15:0] RST_GAIN      = 16'd6554;
	localparam logic [15:0] RST_TBL_START = 16'd15441;
	localparam logic [15:0] RST_IDX_PER   = 16'd25600;
	localparam logic [9:0]  RST_TBL_COUNT = 10'd0;

	typedef enum logic [1:0] {
		REGION_ZERO  = 2'd0,
		REGION_STIFF = 2'd1,
		REGION_TABLE = 2'd2,
		REGION_EMPTY = 2'd3
	} region_t;

	typedef enum logic {
		OP_EVAL  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		CFG_ONSET     = 3'd0,
		CFG_OFFSET    = 3'd1,
		CFG_DAMPING   = 3'd2,
		CFG_GAIN      = 3'd3,
		CFG_TBL_START = 3'd4,
		CFG_IDX_PER   = 3'd5,
		CFG_TBL_COUNT = 3'd6
	} cfg_reg_t;

	// one queued operation; for a table write, value holds the entry data and addr0 the address
	typedef struct packed {
		logic              wr;
		logic              eval;
		region_t           region;
		logic [15:0]       value;
		logic [TBL_AW-1:0] addr0;
		logic [TBL_AW-1:0] addr1;
		logic [FRAC_W-1:0] frac;
	} kptp_entry_t;

endpackage

/* rtl/core/kptp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kptp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/core/kptp_front.sv */
// Front end: config registers, item intake, region classification and address generation.
module kptp_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [63:0]            s_tdata,
	input  logic                   s_tuser,
	input  logic                   q_full,
	output logic                   q_push,
	output kptp_pkg::kptp_entry_t  q_entry
);

	localparam int CNT_W_L = kptp_pkg::CNT_W;

	logic [15:0] onset_q, offset_q, damping_q, gain_q, tbl_start_q, idx_per_q;
	logic [9:0]  tbl_count_q;

	logic        f_adv;
	logic        valid_s1, valid_s2;
	logic        wr_s1, wr_s2;
	logic [17:0] phase_s1;
	logic [15:0] angle_s1;
	logic [8:0]  index_s1, index_s2;
	logic [15:0] value_s1, value_s2;

	kptp_pkg::region_t region_s2;
	logic [30:0]        stiff_prod_s2;
	logic signed [35:0] pos_s2;

	kptp_pkg::region_t region_c;
	logic [14:0]        angle_pos;
	logic signed [18:0] phase_diff;
	logic [16:0]        ph_u;

	logic [31:0]              stiff_sum;
	logic [16:0]              stiff_mag;
	logic [16:0]              stiff_neg;
	logic [15:0]              stiff_torque;
	logic [CNT_W_L-1:0]       n_tbl;
	logic [CNT_W_L-1:0]       n_m1;
	logic [13:0]              i0;
	logic [31:0]              idx32;
	kptp_pkg::kptp_entry_t    entry_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			onset_q     <= kptp_pkg::RST_ONSET;
			offset_q    <= kptp_pkg::RST_OFFSET;
			damping_q   <= kptp_pkg::RST_DAMPING;
			gain_q      <= kptp_pkg::RST_GAIN;
			tbl_start_q <= kptp_pkg::RST_TBL_START;
			idx_per_q   <= kptp_pkg::RST_IDX_PER;
			tbl_count_q <= kptp_pkg::RST_TBL_COUNT;
		end else if (cfg_valid) begin
			case (cfg_index)
				kptp_pkg::CFG_ONSET:     onset_q     <= cfg_data;
				kptp_pkg::CFG_OFFSET:    offset_q    <= cfg_data;
				kptp_pkg::CFG_DAMPING:   damping_q   <= cfg_data;
				kptp_pkg::CFG_GAIN:      gain_q      <= cfg_data;
				kptp_pkg::CFG_TBL_START: tbl_start_q <= cfg_data;
				kptp_pkg::CFG_IDX_PER:   idx_per_q   <= cfg_data;
				kptp_pkg::CFG_TBL_COUNT: tbl_count_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign f_adv    = !valid_s2 || !q_full;
	assign s_tready = f_adv;
	assign q_push   = valid_s2 && !q_full;

	// stage 1: register the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (f_adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (f_adv && s_tvalid) begin
			wr_s1    <= (s_tuser == kptp_pkg::OP_WRITE);
			phase_s1 <= s_tdata[17:0];
			angle_s1 <= s_tdata[33:18];
			index_s1 <= s_tdata[42:34];
			value_s1 <= s_tdata[58:43];
		end
	end

	// classification; a negative phase is out of range before the low bits are looked at
	always_comb begin
		ph_u = phase_s1[16:0];
		if (phase_s1[17] || (32'(ph_u) > kptp_pkg::PHASE_MAX) || (ph_u < {1'b0, onset_q})) begin
			region_c = kptp_pkg::REGION_ZERO;
		end else if (ph_u < {1'b0, offset_q}) begin
			region_c = kptp_pkg::REGION_STIFF;
		end else if (ph_u < {1'b0, damping_q}) begin
			region_c = (tbl_count_q == 10'd0) ? kptp_pkg::REGION_EMPTY : kptp_pkg::REGION_TABLE;
		end else begin
			region_c = kptp_pkg::REGION_ZERO;
		end
	end

	assign angle_pos  = angle_s1[15] ? 15'd0 : angle_s1[14:0];
	assign phase_diff = $signed({phase_s1[17], phase_s1}) - $signed({3'b000, tbl_start_q});

	// stage 2: both products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (f_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (f_adv && valid_s1) begin
			wr_s2         <= wr_s1;
			index_s2      <= index_s1;
			value_s2      <= value_s1;
			region_s2     <= region_c;
			stiff_prod_s2 <= gain_q * angle_pos;
			pos_s2        <= phase_diff * $signed({1'b0, idx_per_q});
		end
	end

	// stiffness torque: round magnitude half away from zero, negate, saturate
	assign stiff_sum    = {1'b0, stiff_prod_s2} + 32'd16384;
	assign stiff_mag    = stiff_sum[31:15];
	assign stiff_neg    = 17'd0 - stiff_mag;
	assign stiff_torque = (stiff_mag > 17'd32768) ? 16'h8000 : stiff_neg[15:0];

	assign n_tbl = (32'(tbl_count_q) > kptp_pkg::TABLE_DEPTH) ?
		CNT_W_L'(kptp_pkg::TABLE_DEPTH) : CNT_W_L'(tbl_count_q);
	assign n_m1  = n_tbl - CNT_W_L'(1);
	assign i0    = pos_s2[34:21];
	assign idx32 = 32'(index_s2);

	always_comb begin
		entry_c        = '0;
		entry_c.wr     = wr_s2 && (idx32 < 32'(kptp_pkg::TABLE_DEPTH));
		entry_c.eval   = !wr_s2;
		entry_c.region = region_s2;
		if (wr_s2) begin
			entry_c.value = value_s2;
			entry_c.addr0 = idx32[kptp_pkg::TBL_AW-1:0];
			entry_c.addr1 = idx32[kptp_pkg::TBL_AW-1:0];
		end else begin
			entry_c.value = (region_s2 == kptp_pkg::REGION_STIFF) ? stiff_torque : 16'd0;
			if (pos_s2[35] || (pos_s2 == 36'sd0)) begin
				entry_c.addr0 = '0;
				entry_c.addr1 = '0;
			end else if (32'(i0) >= 32'(n_m1)) begin
				entry_c.addr0 = n_m1[kptp_pkg::TBL_AW-1:0];
				entry_c.addr1 = n_m1[kptp_pkg::TBL_AW-1:0];
			end else begin
				entry_c.addr0 = i0[kptp_pkg::TBL_AW-1:0];
				entry_c.addr1 = i0[kptp_pkg::TBL_AW-1:0] + kptp_pkg::TBL_AW'(1);
				entry_c.frac  = pos_s2[kptp_pkg::FRAC_W-1:0];
			end
		end
	end

	assign q_entry = entry_c;

endmodule

/* rtl/core/kptp_queue.sv */
// Short FIFO between the front end and the back end.
module kptp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  kptp_pkg::kptp_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output kptp_pkg::kptp_entry_t head_entry
);

	kptp_pkg::kptp_entry_t        ent_q [kptp_pkg::QDEPTH];
	logic [kptp_pkg::QAW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [kptp_pkg::QAW:0]       cnt_q;

	assign full       = (cnt_q == (kptp_pkg::QAW+1)'(kptp_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_entry = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + kptp_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + kptp_pkg::QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (kptp_pkg::QAW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (kptp_pkg::QAW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

/* rtl/core/kptp_back.sv */
// Back end: profile table storage, interpolation pipeline and output register.
module kptp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  kptp_pkg::kptp_entry_t q_entry,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,
	output logic [1:0]            m_tuser
);

	logic        adv;
	logic        tbl_wr;
	logic [15:0] y0, y1;

	logic                      valid_s3, valid_s4;
	kptp_pkg::region_t         region_s3, region_s4;
	logic [15:0]               value_s3, value_s4;
	logic [kptp_pkg::FRAC_W-1:0] frac_s3;
	logic [15:0]               y0_s4;
	logic signed [38:0]        prod_s4;

	logic signed [16:0] dy;
	logic signed [38:0] rnd_sum;
	logic signed [18:0] interp;
	logic [15:0]        interp_sat;

	logic              out_valid_q;
	logic [15:0]       torque_q;
	kptp_pkg::region_t region_q;

	assign adv    = !out_valid_q || m_tready;
	assign q_pop  = adv && q_valid;
	assign tbl_wr = q_pop && q_entry.wr;

	// two copies of the table so that both neighbors are read in the same cycle
	kptp_ram #(
		.WIDTH (16),
		.DEPTH (kptp_pkg::TABLE_DEPTH)
	) u_ram_lo (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (q_entry.addr0),
		.wr_data (q_entry.value),
		.rd_en   (adv),
		.rd_addr (q_entry.addr0),
		.rd_data (y0)
	);

	kptp_ram #(
		.WIDTH (16),
		.DEPTH (kptp_pkg::TABLE_DEPTH)
	) u_ram_hi (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (q_entry.addr0),
		.wr_data (q_entry.value),
		.rd_en   (adv),
		.rd_addr (q_entry.addr1),
		.rd_data (y1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s3    <= q_pop && q_entry.eval;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	assign dy = $signed({y1[15], y1}) - $signed({y0[15], y0});

	always_ff @(posedge clk) begin
		if (adv) begin
			region_s3 <= q_entry.region;
			value_s3  <= q_entry.value;
			frac_s3   <= q_entry.frac;
			region_s4 <= region_s3;
			value_s4  <= value_s3;
			y0_s4     <= y0;
			prod_s4   <= $signed({1'b0, frac_s3}) * dy;
		end
	end

	// y0 + floor((f * dy + half) / 2^21), sign-extended high bits floor
	assign rnd_sum    = prod_s4 + 39'sd1048576;
	assign interp     = $signed({{3{y0_s4[15]}}, y0_s4}) + $signed({rnd_sum[38], rnd_sum[38:21]});
	assign interp_sat = (interp > 19'sd32767)  ? 16'h7FFF :
	                    (interp < -19'sd32768) ? 16'h8000 : interp[15:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			region_q <= region_s4;
			torque_q <= (region_s4 == kptp_pkg::REGION_TABLE) ? interp_sat : value_s4;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = torque_q;
	assign m_tuser  = region_q;

endmodule

/* rtl/core/knee_phase_torque_profile_core.sv */
// Top level of the knee phase torque profile core.
// An evaluate result passes the stage 1 and 2 registers, the queue, the table read and stage 4 registers.
// One item per cycle is taken while no full queue holds the front end; front and back end stall independently.
// A table write passes stages 1 and 2 and the queue, lands in the table when popped, and is seen by every later item.
// Reset: asynchronous, clears control state and loads the config defaults.
// The profile table is not cleared by reset; entries hold no value until written.
module knee_phase_torque_profile_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // gait_phase[17:0], knee_angle[33:18], entry_index[42:34],
	                               // entry_value[58:43], zero fill[63:59]
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // torque[15:0]
	output logic [1:0]  m_tuser    // region
);

	logic                  q_full, q_push, q_pop, q_valid;
	kptp_pkg::kptp_entry_t push_entry, head_entry;

	kptp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (push_entry)
	);

	kptp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_entry (head_entry)
	);

	kptp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (head_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_full)
		else $error("input stalled without a full queue");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !q_pop)
		else $error("queue popped while output stalled");

endmodule

/* tb/testbench.sv */
// Testbench of the knee phase torque profile core: directed table, then random items vs a predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int SETTLE = 10;
	localparam int PHASE_ITEMS = 75;

	typedef struct packed {
		logic [15:0]       torque;
		kptp_pkg::region_t region;
	} torque_res_t;

	typedef struct packed {
		logic               is_cfg;
		kptp_pkg::cfg_reg_t reg_sel;
		logic [15:0]        reg_val;
		kptp_pkg::opcode_t  op;
		logic [17:0]        phase;
		logic [15:0]        angle;
		logic [8:0]         entry_idx;
		logic [15:0]        entry_val;
		logic               typed;
		logic [15:0]        exp_torque;
		kptp_pkg::region_t  exp_region;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	kptp_pkg::cfg_reg_t cfg_index = kptp_pkg::CFG_ONSET;
	logic [15:0]        cfg_data = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [63:0]        s_tdata = '0;
	logic               s_tuser = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [15:0]        m_tdata;
	logic [1:0]         m_tuser;

	// predictor copy of the registers and the profile table
	int                 p_onset   = kptp_pkg::RST_ONSET;
	int                 p_offset  = kptp_pkg::RST_OFFSET;
	int                 p_damping = kptp_pkg::RST_DAMPING;
	int                 p_gain    = kptp_pkg::RST_GAIN;
	int                 p_start   = kptp_pkg::RST_TBL_START;
	int                 p_idx_per = kptp_pkg::RST_IDX_PER;
	int                 p_count   = kptp_pkg::RST_TBL_COUNT;
	logic signed [15:0] p_table [kptp_pkg::TABLE_DEPTH];

	torque_res_t pending_torque[$];
	stim_row_t   dir_rows[$];
	int          mismatch_cnt = 0;
	int          burst_left = 0;

	int          rx_mode = 0;
	int          rx_left = 0;
	int          rx_hold = 0;
	int          rx_beat = 0;
	bit          rx_stalling = 1'b0;
	logic        rx_ready_next;
	torque_res_t rx_want;

	knee_phase_torque_profile_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [15:0] sat16(input longint v);
		if (v > 32767) return 16'h7FFF;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic torque_res_t predict_torque(input logic signed [17:0] phase_in,
			input logic signed [15:0] angle_in);
		torque_res_t res;
		longint ph, ang, mag, pos, i0, fr, y0, y1, n;
		ph = phase_in;
		ang = angle_in;
		res.torque = '0;
		res.region = kptp_pkg::REGION_ZERO;
		n = (p_count > kptp_pkg::TABLE_DEPTH) ? kptp_pkg::TABLE_DEPTH : p_count;
		if (ph < 0 || ph > kptp_pkg::PHASE_MAX || ph < p_onset) begin
			res.region = kptp_pkg::REGION_ZERO;
		end else if (ph < p_offset) begin
			if (ang < 0) ang = 0;
			mag = (p_gain * ang + 16384) >>> 15;
			res.torque = sat16(-mag);
			res.region = kptp_pkg::REGION_STIFF;
		end else if (ph < p_damping) begin
			if (p_count == 0) begin
				res.region = kptp_pkg::REGION_EMPTY;
			end else begin
				res.region = kptp_pkg::REGION_TABLE;
				pos = (ph - p_start) * p_idx_per;
				i0 = pos >>> kptp_pkg::FRAC_W;
				if (pos <= 0) begin
					res.torque = p_table[0];
				end else if (i0 >= n - 1) begin
					res.torque = p_table[n - 1];
				end else begin
					fr = pos & ((longint'(1) <<< kptp_pkg::FRAC_W) - 1);
					y0 = p_table[i0];
					y1 = p_table[i0 + 1];
					res.torque = sat16(y0 + ((fr * (y1 - y0)
						+ (longint'(1) <<< (kptp_pkg::FRAC_W - 1))) >>> kptp_pkg::FRAC_W));
				end
			end
		end
		return res;
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 31))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		$display("%0t: %s", $time, msg);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_torque.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input kptp_pkg::cfg_reg_t sel, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (sel)
			kptp_pkg::CFG_ONSET:     p_onset   = val;
			kptp_pkg::CFG_OFFSET:    p_offset  = val;
			kptp_pkg::CFG_DAMPING:   p_damping = val;
			kptp_pkg::CFG_GAIN:      p_gain    = val;
			kptp_pkg::CFG_TBL_START: p_start   = val;
			kptp_pkg::CFG_IDX_PER:   p_idx_per = val;
			kptp_pkg::CFG_TBL_COUNT: p_count   = val[9:0];
			default: ;
		endcase
	endtask

	task automatic apply_profile(input logic [15:0] onset, input logic [15:0] offset,
			input logic [15:0] damping, input logic [15:0] gain, input logic [15:0] start,
			input logic [15:0] idx_per, input logic [15:0] count);
		drain();
		cfg_write(kptp_pkg::CFG_ONSET, onset);
		cfg_write(kptp_pkg::CFG_OFFSET, offset);
		cfg_write(kptp_pkg::CFG_DAMPING, damping);
		cfg_write(kptp_pkg::CFG_GAIN, gain);
		cfg_write(kptp_pkg::CFG_TBL_START, start);
		cfg_write(kptp_pkg::CFG_IDX_PER, idx_per);
		cfg_write(kptp_pkg::CFG_TBL_COUNT, count);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(input kptp_pkg::opcode_t op, input logic [17:0] phase,
			input logic [15:0] angle, input logic [8:0] entry_idx,
			input logic [15:0] entry_val, input logic typed, input torque_res_t typed_res);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		end
		burst_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, entry_val, entry_idx, angle, phase};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == kptp_pkg::OP_WRITE)
			p_table[entry_idx] = entry_val;
		else
			pending_torque.push_back(typed ? typed_res : predict_torque(phase, angle));
	endtask

	task automatic add_cfg(input kptp_pkg::cfg_reg_t sel, input logic [15:0] val);
		stim_row_t r;
		r = '0;
		r.is_cfg  = 1'b1;
		r.reg_sel = sel;
		r.reg_val = val;
		dir_rows.push_back(r);
	endtask

	task automatic add_write(input logic [8:0] idx, input logic [15:0] val);
		stim_row_t r;
		r = '0;
		r.op        = kptp_pkg::OP_WRITE;
		r.phase     = $urandom;
		r.angle     = $urandom;
		r.entry_idx = idx;
		r.entry_val = val;
		dir_rows.push_back(r);
	endtask

	task automatic add_eval(input logic [17:0] phase, input logic [15:0] angle,
			input logic typed, input logic [15:0] torque, input kptp_pkg::region_t region);
		stim_row_t r;
		r = '0;
		r.op         = kptp_pkg::OP_EVAL;
		r.phase      = phase;
		r.angle      = angle;
		r.entry_idx  = $urandom;
		r.entry_val  = $urandom;
		r.typed      = typed;
		r.exp_torque = torque;
		r.exp_region = region;
		dir_rows.push_back(r);
	endtask

	// result side: random stall patterns, compare against oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_torque.size() == 0) begin
					report_mismatch($sformatf("unexpected result: torque %0d region %0d",
						$signed(m_tdata), m_tuser));
				end else begin
					rx_want = pending_torque.pop_front();
					if (m_tdata !== rx_want.torque)
						report_mismatch($sformatf("torque: got %0d, want %0d",
							$signed(m_tdata), $signed(rx_want.torque)));
					if (m_tuser !== rx_want.region)
						report_mismatch($sformatf("region: got %0d, want %0d",
							m_tuser, rx_want.region));
				end
			end
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(50, 300);
			end
			rx_left--;
			case (rx_mode)
				0: rx_ready_next = 1'b1;
				1: rx_ready_next = $urandom_range(0, 1);
				2: begin
					rx_beat = (rx_beat + 1) % 3;
					rx_ready_next = (rx_beat == 0);
				end
				default: begin
					if (rx_hold == 0) begin
						rx_stalling = !rx_stalling;
						rx_hold = rx_stalling ? $urandom_range(1, 16) : $urandom_range(1, 6);
					end
					rx_hold--;
					rx_ready_next = !rx_stalling;
				end
			endcase
			m_tready <= rx_ready_next;
		end
	end

	initial begin
		stim_row_t   row;
		torque_res_t want;
		int          ph, k, a, b, c, t, st, ip, cnt, phase;

		// reset defaults
		add_eval(-1, 100, 1'b1, 0, kptp_pkg::REGION_ZERO);
		add_eval(-131072, -32768, 1'b1, 0, kptp_pkg::REGION_ZERO);
		add_eval(kptp_pkg::PHASE_MAX + 1, 1000, 1'b1, 0, kptp_pkg::REGION_ZERO);
		add_eval(131071, 32767, 1'b1, 0, kptp_pkg::REGION_ZERO);
		add_eval(0, 32767, 1'b1, 0, kptp_pkg::REGION_ZERO);
		add_eval(1543, 32767, 1'b1, 0, kptp_pkg::REGION_ZERO);
		add_eval(1544, 0, 1'b1, 0, kptp_pkg::REGION_STIFF);
		add_eval(1544, -32768, 1'b1, 0, kptp_pkg::REGION_STIFF);
		add_eval(15440, 32767, 1'b0, 0, kptp_pkg::REGION_ZERO);
		add_eval(15441, 5, 1'b1, 0, kptp_pkg::REGION_EMPTY);
		add_eval(41177, 32767, 1'b1, 0, kptp_pkg::REGION_ZERO);
		// small table, interpolation and clamping
		add_write(0, 16'h7FFF);
		add_write(1, 16'h8000);
		add_write(2, 1000);
		add_write(3, -1000);
		add_write(511, 16'h8000);
		add_cfg(kptp_pkg::CFG_TBL_COUNT, 4);
		add_eval(15441, 0, 1'b1, 16'h7FFF, kptp_pkg::REGION_TABLE);
		add_eval(15441 + 41, 0, 1'b0, 0, kptp_pkg::REGION_ZERO);
		add_eval(15441 + 82, 0, 1'b0, 0, kptp_pkg::REGION_ZERO);
		add_eval(41176, 0, 1'b1, -1000, kptp_pkg::REGION_TABLE);
		// full-scale gain saturates
		add_cfg(kptp_pkg::CFG_GAIN, 16'hFFFF);
		add_eval(2000, 32767, 1'b1, 16'h8000, kptp_pkg::REGION_STIFF);
		add_eval(2000, 1, 1'b0, 0, kptp_pkg::REGION_ZERO);
		// oversized count clamps to the last entry of the table
		add_cfg(kptp_pkg::CFG_TBL_COUNT, 1023);
		add_cfg(kptp_pkg::CFG_TBL_START, 0);
		add_cfg(kptp_pkg::CFG_IDX_PER, 16'hFFFF);
		add_eval(41176, 0, 1'b1, 16'h8000, kptp_pkg::REGION_TABLE);
		// phase ahead of the table start reads entry 0
		add_cfg(kptp_pkg::CFG_TBL_START, 16'hFFFF);
		add_eval(20000, 0, 1'b1, 16'h7FFF, kptp_pkg::REGION_TABLE);
		// damping onset below stiffness offset empties the table region
		add_cfg(kptp_pkg::CFG_DAMPING, 10000);
		add_eval(20000, 0, 1'b1, 0, kptp_pkg::REGION_ZERO);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_cfg) begin
				drain();
				cfg_write(row.reg_sel, row.reg_val);
				cfg_valid <= 1'b0;
			end else begin
				want.torque = row.exp_torque;
				want.region = row.exp_region;
				send_item(row.op, row.phase, row.angle, row.entry_idx, row.entry_val,
					row.typed, want);
			end
		end

		// load every entry so any later read is defined
		for (k = 0; k < kptp_pkg::TABLE_DEPTH; k++)
			send_item(kptp_pkg::OP_WRITE, $urandom, $urandom, k, pick_word(), 1'b0, '0);

		for (ph = 0; ph < 10; ph++) begin
			case (ph)
				0: apply_profile(kptp_pkg::RST_ONSET, kptp_pkg::RST_OFFSET,
					kptp_pkg::RST_DAMPING, kptp_pkg::RST_GAIN, kptp_pkg::RST_TBL_START,
					kptp_pkg::RST_IDX_PER, 512);
				1: apply_profile(0, 0, 16'hFFFF, 0, 0, 16'hFFFF, 512);
				2: apply_profile(0, 30000, 30000, 16'hFFFF, 16'hFFFF, 0, 1023);
				3: apply_profile(1000, 20000, 50000, 1, 40000, 300, 2);
				4: apply_profile(40000, 10000, 5000, 12345, 0, 25600, 0);
				default: begin
					a = $urandom_range(0, kptp_pkg::PHASE_MAX);
					b = $urandom_range(0, kptp_pkg::PHASE_MAX);
					c = $urandom_range(0, kptp_pkg::PHASE_MAX);
					if (a > b) begin t = a; a = b; b = t; end
					if (b > c) begin t = b; b = c; c = t; end
					if (a > b) begin t = a; a = b; b = t; end
					if ($urandom_range(0, 4) == 0) begin
						a = $urandom_range(0, 65535);
						b = $urandom_range(0, 65535);
						c = $urandom_range(0, 65535);
					end
					st = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
						: ((b > 2000) ? b - $urandom_range(0, 2000) : 0);
					ip = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(1, 3000);
					case ($urandom_range(0, 7))
						0: cnt = 0;
						1: cnt = $urandom_range(513, 1023);
						default: cnt = $urandom_range(1, 512);
					endcase
					apply_profile(a, b, c, $urandom, st, ip, cnt);
				end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 149) == 0) drain();
				if ($urandom_range(0, 3) == 0) begin
					send_item(kptp_pkg::OP_WRITE, $urandom, $urandom, $urandom, pick_word(),
						1'b0, '0);
				end else begin
					case ($urandom_range(0, 9))
						0: phase = $urandom;
						1, 2: begin
							case ($urandom_range(0, 4))
								0: phase = p_onset;
								1: phase = p_offset;
								2: phase = p_damping;
								3: phase = 0;
								default: phase = kptp_pkg::PHASE_MAX;
							endcase
							phase = phase + $urandom_range(0, 4) - 2;
						end
						default: phase = $urandom_range(0, kptp_pkg::PHASE_MAX);
					endcase
					send_item(kptp_pkg::OP_EVAL, phase, pick_word(), $urandom, $urandom,
						1'b0, '0);
				end
			end
		end

		s_tvalid <= 1'b0;
		for (k = 0; k < 4000 && pending_torque.size() != 0; k++) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (pending_torque.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_torque.size()));
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
